FILE: src/jse_pkg.sv
// Shared types, constants and helper functions for the JSON string escaper.
package jse_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned NBytes = 6;
  localparam int unsigned CntW   = 3;

  localparam logic [CpW-1:0] SurrLo  = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi  = 21'h00DFFF;
  localparam logic [CpW-1:0] CpMax   = 21'h10FFFF;
  localparam logic [CpW-1:0] CtrlMax = 21'd31;
  localparam logic [CpW-1:0] LtChar  = 21'h00003C;
  localparam logic [CpW-1:0] DelChar = 21'd127;
  localparam logic [CpW-1:0] LineSep = 21'h002028;
  localparam logic [CpW-1:0] ParaSep = 21'h002029;

  localparam logic [7:0] AsciiBslash = 8'h5C;
  localparam logic [7:0] AsciiU      = 8'h75;

  localparam logic [CntW-1:0] CntNone  = 3'd0;
  localparam logic [CntW-1:0] CntOne   = 3'd1;
  localparam logic [CntW-1:0] CntTwo   = 3'd2;
  localparam logic [CntW-1:0] CntThree = 3'd3;
  localparam logic [CntW-1:0] CntFour  = 3'd4;
  localparam logic [CntW-1:0] CntSix   = 3'd6;

  typedef struct packed {
    logic [NBytes-1:0][7:0] bytes;
    logic [CntW-1:0]        count;
    logic                   bad;
  } jse_result_t;

  // returns 0 when the code point has no two-byte escape
  function automatic logic [7:0] short_escape(input logic [CpW-1:0] c);
    logic [7:0] r;
    case (c)
      21'd8:     r = 8'h62;  // b
      21'd9:     r = 8'h74;  // t
      21'd10:    r = 8'h6E;  // n
      21'd12:    r = 8'h66;  // f
      21'd13:    r = 8'h72;  // r
      21'h22:    r = 8'h22;  // "
      21'h5C:    r = 8'h5C;  // backslash
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'h0, n};
    end else begin
      r = 8'h57 + {4'h0, n};
    end
    return r;
  endfunction

endpackage

FILE: src/json_string_escaper.sv
// Top level of the JSON string escaper: input register, encoder, result register.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  s_axis  | in  | code_point[20:0], zero pad to 24            | -
//  m_axis  | out | byte0..byte5, byte_count[2:0], pad to 56     | bad_code_point
//
// One transaction per cycle sustained while m_axis does not stall; a transaction
// passes the input register, then the result register, the encoder sitting between them.
// Reset clears only the two valid flags; payload registers are not reset.
// A stall on m_axis holds the result register; the input register still takes
// a new transaction while it is empty or moving into the result register.
module json_string_escaper import jse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // code_point[20:0], zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // byte0..byte5, byte_count, zero pad
  output logic        m_axis_tuser_o    // bad_code_point
);

  logic           in_valid_q;
  logic [CpW-1:0] in_cp_q;
  logic           out_valid_q;
  jse_result_t    out_res_q;
  jse_result_t    enc_res;
  logic           out_ready;
  logic           in_ready;

  assign out_ready = !out_valid_q || m_axis_tready_i;
  assign in_ready  = !in_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      in_cp_q <= s_axis_tdata_i[CpW-1:0];
    end
  end

  jse_encode u_encode (
    .cp_i  (in_cp_q),
    .res_o (enc_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      out_res_q <= enc_res;
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_res_q.count, out_res_q.bytes[5], out_res_q.bytes[4],
                            out_res_q.bytes[3], out_res_q.bytes[2], out_res_q.bytes[1],
                            out_res_q.bytes[0]};
  assign m_axis_tuser_o  = out_res_q.bad;

  a_bad_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.bad |-> out_res_q.count == CntNone && out_res_q.bytes == '0)
    else $error("bad code point carries bytes");

  a_good_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_res_q.bad |-> out_res_q.count != CntNone)
    else $error("valid code point with zero bytes");

  a_uesc_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.count == CntSix |->
      out_res_q.bytes[0] == AsciiBslash && out_res_q.bytes[1] == AsciiU)
    else $error("six-byte result without u escape prefix");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_ready |=> in_valid_q && $stable(in_cp_q))
    else $error("input register lost a stalled transaction");

endmodule

FILE: src/jse_encode.sv
// Combinational escape or UTF-8 encoding of a code point, or a bad flag.
module jse_encode import jse_pkg::*; (
  input  logic [CpW-1:0] cp_i,
  output jse_result_t    res_o
);

  logic [7:0] letter;
  logic       is_bad;
  logic       is_uesc;

  assign letter  = short_escape(cp_i);
  assign is_bad  = (cp_i >= SurrLo && cp_i <= SurrHi) || (cp_i > CpMax);
  assign is_uesc = (cp_i <= CtrlMax) || (cp_i == LtChar) || (cp_i == DelChar) ||
                   (cp_i == LineSep) || (cp_i == ParaSep);

  always_comb begin
    res_o = '0;
    if (is_bad) begin
      res_o.bad = 1'b1;
    end else if (letter != 8'h00) begin
      res_o.bytes[0] = AsciiBslash;
      res_o.bytes[1] = letter;
      res_o.count    = CntTwo;
    end else if (is_uesc) begin
      res_o.bytes[0] = AsciiBslash;
      res_o.bytes[1] = AsciiU;
      res_o.bytes[2] = hex_digit(cp_i[15:12]);
      res_o.bytes[3] = hex_digit(cp_i[11:8]);
      res_o.bytes[4] = hex_digit(cp_i[7:4]);
      res_o.bytes[5] = hex_digit(cp_i[3:0]);
      res_o.count    = CntSix;
    end else if (cp_i < 21'h80) begin
      res_o.bytes[0] = {1'b0, cp_i[6:0]};
      res_o.count    = CntOne;
    end else if (cp_i < 21'h800) begin
      res_o.bytes[0] = {3'b110, cp_i[10:6]};
      res_o.bytes[1] = {2'b10, cp_i[5:0]};
      res_o.count    = CntTwo;
    end else if (cp_i < 21'h10000) begin
      res_o.bytes[0] = {4'b1110, cp_i[15:12]};
      res_o.bytes[1] = {2'b10, cp_i[11:6]};
      res_o.bytes[2] = {2'b10, cp_i[5:0]};
      res_o.count    = CntThree;
    end else begin
      res_o.bytes[0] = {5'b11110, cp_i[20:18]};
      res_o.bytes[1] = {2'b10, cp_i[17:12]};
      res_o.bytes[2] = {2'b10, cp_i[11:6]};
      res_o.bytes[3] = {2'b10, cp_i[5:0]};
      res_o.count    = CntFour;
    end
  end

endmodule

FILE: test/json_string_escaper_tb.sv
// Self-checking testbench for the JSON string escaper stream block.
`timescale 1ns / 1ps

module json_string_escaper_tb;
  import jse_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;   // code_point[20:0], zero pad
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;        // byte0..byte5, byte_count, zero pad
  logic        m_axis_tuser_o;        // bad_code_point

  jse_result_t pending_escapes[$];
  int unsigned mismatch_count = 0;
  bit          gaps_on = 1'b0;

  json_string_escaper i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + 8'(nib);
    end
    return 8'h61 + 8'(nib) - 8'd10;
  endfunction

  function automatic jse_result_t escape_code_point(input logic [CpW-1:0] cp);
    jse_result_t r;
    logic [7:0]  letter;
    r = '0;
    case (cp)
      21'd8:   letter = "b";
      21'd9:   letter = "t";
      21'd10:  letter = "n";
      21'd12:  letter = "f";
      21'd13:  letter = "r";
      21'h22:  letter = 8'h22;
      21'h5C:  letter = AsciiBslash;
      default: letter = 8'h00;
    endcase
    if ((cp >= SurrLo && cp <= SurrHi) || cp > CpMax) begin
      r.bad = 1'b1;
      r.count = CntNone;
    end else if (letter != 8'h00) begin
      r.bytes[0] = AsciiBslash;
      r.bytes[1] = letter;
      r.count = CntTwo;
    end else if (cp <= CtrlMax || cp == LtChar || cp == DelChar ||
                 cp == LineSep || cp == ParaSep) begin
      r.bytes[0] = AsciiBslash;
      r.bytes[1] = AsciiU;
      r.bytes[2] = hex_char(cp[15:12]);
      r.bytes[3] = hex_char(cp[11:8]);
      r.bytes[4] = hex_char(cp[7:4]);
      r.bytes[5] = hex_char(cp[3:0]);
      r.count = CntSix;
    end else if (cp < 21'h80) begin
      r.bytes[0] = cp[7:0];
      r.count = CntOne;
    end else if (cp < 21'h800) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.count = CntTwo;
    end else if (cp < 21'h10000) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.count = CntThree;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.count = CntFour;
    end
    return r;
  endfunction

  // called at a rising edge; returns at the rising edge that took the transaction
  task automatic send_code_point(input logic [CpW-1:0] cp);
    if (gaps_on) begin
      while ($urandom_range(99) < 31) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, cp};
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    pending_escapes.push_back(escape_code_point(cp));
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_escapes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [CpW-1:0] random_code_point();
    logic [CpW-1:0] specials[13] = '{21'd8, 21'd9, 21'd10, 21'd12, 21'd13, 21'h22,
                                      21'h5C, LtChar, DelChar, LineSep, ParaSep,
                                      21'd0, CtrlMax};
    case ($urandom_range(9))
      0:       return CpW'($urandom_range(0, 21'h7F));
      1:       return specials[$urandom_range(12)];
      2:       return CpW'($urandom_range(21'h80, 21'h7FF));
      3:       return CpW'($urandom_range(21'h800, 21'hFFFF));
      4:       return CpW'($urandom_range(21'h10000, CpMax));
      5:       return CpW'($urandom_range(SurrLo, SurrHi));
      6:       return CpW'($urandom_range(CpMax + 21'd1, 21'h1FFFFF));
      7:       return CpW'($urandom_range(21'h2020, 21'h202F));
      default: return CpW'($urandom_range(0, 21'h1FFFFF));
    endcase
  endfunction

  task automatic test_short_escapes();
    logic [CpW-1:0] cps[7] = '{21'd8, 21'd9, 21'd10, 21'd12, 21'd13, 21'h22, 21'h5C};
    gaps_on = 1'b0;
    foreach (cps[i]) send_code_point(cps[i]);
  endtask

  task automatic test_unicode_escapes();
    logic [CpW-1:0] cps[7] = '{21'd0, 21'd11, CtrlMax, LtChar, DelChar, LineSep, ParaSep};
    gaps_on = 1'b1;
    foreach (cps[i]) send_code_point(cps[i]);
  endtask

  task automatic test_utf8_lengths();
    logic [CpW-1:0] cps[7] = '{21'h41, 21'h7E, 21'h80, 21'h7FF, 21'h800, 21'hFFFF,
                               21'h10000};
    gaps_on = 1'b0;
    foreach (cps[i]) send_code_point(cps[i]);
    send_code_point(CpMax);
  endtask

  task automatic test_bad_code_points();
    gaps_on = 1'b1;
    send_code_point(SurrLo);
    send_code_point(SurrHi);
    send_code_point(CpMax + 21'd1);
    send_code_point(21'h1FFFFF);
  endtask

  task automatic test_random_stream(input int unsigned n_items, input bit with_gaps);
    gaps_on = with_gaps;
    repeat (n_items) send_code_point(random_code_point());
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= gaps_on ? ($urandom_range(99) >= 31) : 1'b1;
  end

  // transaction happens at the next rising edge; sample while stable
  always @(negedge clk_i) begin
    jse_result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_escapes.size() == 0) begin
        $error("unexpected result transaction: tdata %h tuser %b",
               m_axis_tdata_o, m_axis_tuser_o);
        mismatch_count++;
      end else begin
        exp_r = pending_escapes.pop_front();
        for (int k = 0; k < NBytes; k++) begin
          if (m_axis_tdata_o[8*k +: 8] !== exp_r.bytes[k]) begin
            $error("byte%0d: expected %h, got %h", k, exp_r.bytes[k],
                   m_axis_tdata_o[8*k +: 8]);
            mismatch_count++;
          end
        end
        if (m_axis_tdata_o[50:48] !== exp_r.count) begin
          $error("byte_count: expected %0d, got %0d", exp_r.count, m_axis_tdata_o[50:48]);
          mismatch_count++;
        end
        if (m_axis_tuser_o !== exp_r.bad) begin
          $error("bad_code_point: expected %b, got %b", exp_r.bad, m_axis_tuser_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_escapes();
    test_unicode_escapes();
    test_utf8_lengths();
    test_bad_code_points();
    test_random_stream(700, 1'b1);
    // hold off until the pipe is empty, then go again
    wait_drained();
    test_random_stream(350, 1'b0);
    test_random_stream(600, 1'b1);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
src/jse_pkg.sv
src/jse_encode.sv
src/json_string_escaper.sv
test/json_string_escaper_tb.sv
